@@ hdl/ffba_pkg.sv @@
`default_nettype none

package ffba_pkg;

  localparam int BLK_W  = 10;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_GRANTED   = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FREED     = 2'd2;
  localparam logic [STAT_W-1:0] ST_REJECTED  = 2'd3;

  typedef struct packed {
    logic              req_load;
    logic              clear_wr;
    logic              ptr_zero;
    logic              ptr_inc;
    logic              ptr_load_fb;
    logic              rd;
    logic              load_cur;
    logic              free_wr;
    logic              grant;
    logic              emit;
    logic [STAT_W-1:0] emit_status;
  } ffba_cmd_t;

  typedef struct packed {
    logic req_free;
    logic req_zero;
    logic fb_ok;
    logic ptr_last;
    logic cur_has_free;
    logic grant_last;
    logic out_free;
  } ffba_stat_t;

endpackage

`default_nettype wire

@@ hdl/ffba_dp.sv @@
`default_nettype none

module ffba_dp #(
  parameter int NUM_BLOCKS      = 1024,
  parameter int MAX_PER_REQUEST = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ffba_pkg::ffba_cmd_t           cmd,
  output ffba_pkg::ffba_stat_t               stat,
  input  wire logic                          kind,
  input  wire logic [ffba_pkg::CNT_W-1:0]    count,
  input  wire logic [ffba_pkg::BLK_W-1:0]    free_block,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output logic [ffba_pkg::BLK_W-1:0]         granted_block,
  output logic [ffba_pkg::STAT_W-1:0]        status,
  output logic                               last
);
  import ffba_pkg::*;

  localparam int WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW    = AW + BIT_W;
  localparam int DW    = 2 * WORD_W;
  localparam logic [DW-1:0] TAIL_FULL =
    ~((DW'(1) << (NUM_BLOCKS - (WORDS - 1) * WORD_W)) - DW'(1));
  localparam logic [WORD_W-1:0] TAIL_MASK = TAIL_FULL[WORD_W-1:0];
  localparam logic [AW-1:0]     LAST_PTR  = AW'(WORDS - 1);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] cur;
  logic [WORD_W-1:0] scan_word;
  logic [WORD_W-1:0] hit_mask;
  logic [WORD_W-1:0] fb_mask;
  logic [WORD_W-1:0] init_word;
  logic [WORD_W-1:0] wdata;
  logic              wr_en;
  logic [AW-1:0]     ptr;
  logic [BIT_W-1:0]  hit_idx;
  logic              hit;
  logic              req_kind;
  logic [CNT_W-1:0]  want;
  logic [CNT_W-1:0]  want_sat;
  logic [CNT_W-1:0]  n;
  logic [BW-1:0]     fb;
  logic              fb_ok;

  // block 0 is never handed out by the scan
  assign scan_word = cur | ((ptr == '0) ? WORD_W'(1) : '0);

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!scan_word[i]) begin
        hit     = 1'b1;
        hit_idx = BIT_W'(i);
      end
    end
  end

  assign hit_mask  = WORD_W'(1) << hit_idx;
  assign fb_mask   = WORD_W'(1) << fb[BIT_W-1:0];
  assign init_word = ((ptr == '0) ? WORD_W'(1) : '0) |
                     ((ptr == LAST_PTR) ? TAIL_MASK : '0);

  always_comb begin
    if (cmd.clear_wr) begin
      wdata = init_word;
    end else if (cmd.free_wr) begin
      wdata = rdata & ~fb_mask;
    end else begin
      wdata = cur | hit_mask;
    end
  end

  assign wr_en = cmd.clear_wr | cmd.free_wr | cmd.grant;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ptr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[ptr];
    end
  end

  assign want_sat = (int'(count) > MAX_PER_REQUEST) ? CNT_W'(MAX_PER_REQUEST) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      n         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.ptr_zero) begin
        ptr <= '0;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + AW'(1);
      end else if (cmd.ptr_load_fb) begin
        ptr <= fb[BW-1:BIT_W];
      end
      if (cmd.req_load) begin
        n <= '0;
      end else if (cmd.grant) begin
        n <= n + CNT_W'(1);
      end
      if (cmd.grant || cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_kind <= kind;
      want     <= want_sat;
      fb       <= BW'(free_block);
      fb_ok    <= int'(free_block) < NUM_BLOCKS;
    end
    if (cmd.load_cur) begin
      cur <= rdata;
    end else if (cmd.grant) begin
      cur <= cur | hit_mask;
    end
    if (cmd.grant) begin
      granted_block <= BLK_W'({ptr, hit_idx});
      status        <= ST_GRANTED;
      last          <= stat.grant_last;
    end else if (cmd.emit) begin
      granted_block <= '0;
      status        <= cmd.emit_status;
      last          <= 1'b1;
    end
  end

  assign stat.req_free     = (req_kind == KIND_FREE);
  assign stat.req_zero     = (want == '0);
  assign stat.fb_ok        = fb_ok;
  assign stat.ptr_last     = (ptr == LAST_PTR);
  assign stat.cur_has_free = hit;
  assign stat.grant_last   = ((n + CNT_W'(1)) == want);
  assign stat.out_free     = !rsp_valid || !rsp_stall;

endmodule

`default_nettype wire

@@ hdl/ffba_ctrl.sv @@
`default_nettype none

module ffba_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  output ffba_pkg::ffba_cmd_t       cmd,
  input  wire ffba_pkg::ffba_stat_t stat
);
  import ffba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_FREE_RD,
    S_FREE_WR,
    S_ALLOC_RD,
    S_ALLOC_LD,
    S_ALLOC_SCAN,
    S_EMIT
  } state_t;

  state_t            state, state_next;
  logic [STAT_W-1:0] emit_st, emit_st_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.emit_status = emit_st;
    state_next      = state;
    emit_st_next    = emit_st;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.ptr_last) begin
          cmd.ptr_zero = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.req_load = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.req_free) begin
          if (stat.fb_ok) begin
            cmd.ptr_load_fb = 1'b1;
            state_next      = S_FREE_RD;
          end else begin
            emit_st_next = ST_FREED;
            state_next   = S_EMIT;
          end
        end else if (stat.req_zero) begin
          emit_st_next = ST_REJECTED;
          state_next   = S_EMIT;
        end else begin
          cmd.ptr_zero = 1'b1;
          state_next   = S_ALLOC_RD;
        end
      end
      S_FREE_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.free_wr  = 1'b1;
        emit_st_next = ST_FREED;
        state_next   = S_EMIT;
      end
      S_ALLOC_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_ALLOC_LD;
      end
      S_ALLOC_LD: begin
        cmd.load_cur = 1'b1;
        state_next   = S_ALLOC_SCAN;
      end
      S_ALLOC_SCAN: begin
        if (stat.cur_has_free) begin
          if (stat.out_free) begin
            cmd.grant = 1'b1;
            if (stat.grant_last) begin
              state_next = S_IDLE;
            end
          end
        end else if (stat.ptr_last) begin
          emit_st_next = ST_EXHAUSTED;
          state_next   = S_EMIT;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_ALLOC_RD;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      emit_st <= ST_FREED;
    end else begin
      state   <= state_next;
      emit_st <= emit_st_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/first_fit_block_allocator.sv @@
// First-fit block allocator. One used/free bit per block, held in a memory of
// 32-bit words; after reset block 0 is used and all others are free. After
// reset the block runs a clearing pass over every word with req_stall high.
// A free item gives a single result. An allocate item reads the words in
// turn from word 0 and grants the free blocks of each word one after another,
// waiting while a result in the output register is held by rsp_stall; the
// word memory is single-port with a registered read. Requests wider than
// MAX_PER_REQUEST are cut to it, a count of zero is rejected, and running out
// of blocks ends the item with an exhausted result. Results pass through one
// output register, so a new item is taken while the last result still waits
// on rsp_stall.
`default_nettype none

module first_fit_block_allocator #(
  parameter int NUM_BLOCKS      = 1024,
  parameter int MAX_PER_REQUEST = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire logic                        kind,
  input  wire logic [ffba_pkg::CNT_W-1:0]  count,
  input  wire logic [ffba_pkg::BLK_W-1:0]  free_block,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output logic [ffba_pkg::BLK_W-1:0]       granted_block,
  output logic [ffba_pkg::STAT_W-1:0]      status,
  output logic                             last
);
  import ffba_pkg::*;

  ffba_cmd_t  cmd;
  ffba_stat_t stat;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  ffba_dp #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .MAX_PER_REQUEST (MAX_PER_REQUEST)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (kind),
    .count         (count),
    .free_block    (free_block),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .granted_block (granted_block),
    .status        (status),
    .last          (last)
  );

endmodule

`default_nettype wire

@@ hdl/ffba_chk.sv @@
`default_nettype none

module ffba_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_stall,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_stall,
  input wire logic [ffba_pkg::BLK_W-1:0]  granted_block,
  input wire logic [ffba_pkg::STAT_W-1:0] status,
  input wire logic                        last
);
  import ffba_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=>
      rsp_valid && $stable(granted_block) && $stable(status) && $stable(last))
    else $error("stalled result item changed");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> req_stall && !rsp_valid)
    else $error("item traffic right after reset");

  a_non_grant_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_GRANTED) |-> (granted_block == '0) && last)
    else $error("non-grant result item not final or carries a block");

  a_no_root_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_GRANTED) |-> (granted_block != '0))
    else $error("block 0 granted");

endmodule

bind first_fit_block_allocator ffba_chk u_ffba_chk (.*);

`default_nettype wire

@@ tb/first_fit_block_allocator_tb.sv @@
`default_nettype none

module first_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;

  localparam int NBLK     = 1024;
  localparam int MAX_REQ  = 16;
  localparam int N_RAND   = 96;
  localparam int LIMIT    = 400000;
  localparam int DIR_N    = 14;

  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [STAT_W-1:0] st;
    logic              fin;
  } alloc_res_t;

  typedef struct packed {
    logic              kind;
    logic [CNT_W-1:0]  cnt;
    logic [BLK_W-1:0]  blk;
    logic              typed;
    logic [BLK_W-1:0]  t_blk;
    logic [STAT_W-1:0] t_st;
  } dir_row_t;

  // typed rows answer exactly one result with last set
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{KIND_ALLOC, 5'd0,  10'd1023, 1'b1, 10'd0,    ST_REJECTED},
    '{KIND_ALLOC, 5'd1,  10'd0,    1'b1, 10'd1,    ST_GRANTED},
    '{KIND_ALLOC, 5'd16, 10'd341,  1'b0, 10'd0,    ST_GRANTED},
    '{KIND_ALLOC, 5'd31, 10'd682,  1'b0, 10'd0,    ST_GRANTED},
    '{KIND_ALLOC, 5'd17, 10'd0,    1'b0, 10'd0,    ST_GRANTED},
    '{KIND_FREE,  5'd0,  10'd1,    1'b1, 10'd0,    ST_FREED},
    '{KIND_FREE,  5'd31, 10'd0,    1'b1, 10'd0,    ST_FREED},
    '{KIND_FREE,  5'd16, 10'd1,    1'b1, 10'd0,    ST_FREED},
    '{KIND_ALLOC, 5'd2,  10'd1023, 1'b0, 10'd0,    ST_GRANTED},
    '{KIND_FREE,  5'd0,  10'd1023, 1'b1, 10'd0,    ST_FREED},
    '{KIND_FREE,  5'd21, 10'd512,  1'b1, 10'd0,    ST_FREED},
    '{KIND_ALLOC, 5'd0,  10'd682,  1'b1, 10'd0,    ST_REJECTED},
    '{KIND_FREE,  5'd10, 10'd20,   1'b1, 10'd0,    ST_FREED},
    '{KIND_ALLOC, 5'd3,  10'd5,    1'b0, 10'd0,    ST_GRANTED}
  };

  logic              clk;
  logic              rst        = 1'b1;
  logic              req_valid  = 1'b0;
  logic              req_stall;
  logic              kind       = KIND_ALLOC;
  logic [CNT_W-1:0]  count      = '0;
  logic [BLK_W-1:0]  free_block = '0;
  logic              rsp_valid;
  logic              rsp_stall  = 1'b0;
  logic [BLK_W-1:0]  granted_block;
  logic [STAT_W-1:0] status;
  logic              last;

  logic [NBLK-1:0]   blk_used;
  alloc_res_t        grant_q [$];
  alloc_res_t        step_res [$];
  int                err_cnt  = 0;
  int                cyc_cnt  = 0;
  bit                tx_burst = 1'b0;

  first_fit_block_allocator #(
    .NUM_BLOCKS      (NBLK),
    .MAX_PER_REQUEST (MAX_REQ)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .kind          (kind),
    .count         (count),
    .free_block    (free_block),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .granted_block (granted_block),
    .status        (status),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cyc_cnt <= cyc_cnt + 1;

  initial begin
    wait (cyc_cnt >= LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // first-fit scan from block 1; fills step_res with the results of one item
  function automatic void alloc_map_step(input logic k, input logic [CNT_W-1:0] c,
                                         input logic [BLK_W-1:0] b);
    int want;
    int got;
    step_res.delete();
    if (k == KIND_FREE) begin
      if (int'(b) < NBLK) blk_used[b] = 1'b0;
      step_res.push_back('{blk: '0, st: ST_FREED, fin: 1'b1});
    end else if (c == '0) begin
      step_res.push_back('{blk: '0, st: ST_REJECTED, fin: 1'b1});
    end else begin
      want = (int'(c) > MAX_REQ) ? MAX_REQ : int'(c);
      got  = 0;
      for (int i = 1; i < NBLK && got < want; i++) begin
        if (!blk_used[i]) begin
          blk_used[i] = 1'b1;
          got++;
          step_res.push_back('{blk: BLK_W'(i), st: ST_GRANTED, fin: (got == want)});
        end
      end
      if (got < want) step_res.push_back('{blk: '0, st: ST_EXHAUSTED, fin: 1'b1});
    end
  endfunction

  task automatic offer_item(input logic k, input logic [CNT_W-1:0] c,
                            input logic [BLK_W-1:0] b, input logic typed,
                            input logic [BLK_W-1:0] t_blk, input logic [STAT_W-1:0] t_st);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    kind       <= k;
    count      <= c;
    free_block <= b;
    do @(posedge clk); while (req_stall);
    alloc_map_step(k, c, b);
    if (typed) begin
      grant_q.push_back('{blk: t_blk, st: t_st, fin: 1'b1});
    end else begin
      foreach (step_res[i]) grant_q.push_back(step_res[i]);
    end
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
  endtask

  // result side: random hold-off per item, one long hold to back up the block
  initial begin : rsp_side
    int hold;
    int n_seen;
    bit burst;
    alloc_res_t want_r;
    hold   = 0;
    n_seen = 0;
    burst  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result: granted_block %0d status %0d last %0d",
                 granted_block, status, last);
          err_cnt++;
        end else begin
          want_r = grant_q.pop_front();
          if (granted_block !== want_r.blk) begin
            $error("granted_block: expected %0d, got %0d", want_r.blk, granted_block);
            err_cnt++;
          end
          if (status !== want_r.st) begin
            $error("status: expected %0d, got %0d", want_r.st, status);
            err_cnt++;
          end
          if (last !== want_r.fin) begin
            $error("last: expected %0d, got %0d", want_r.fin, last);
            err_cnt++;
          end
        end
        n_seen++;
        hold = burst ? 0 : $urandom_range(0, 18);
        if (n_seen == 60) hold = 400;
        if ($urandom_range(0, 15) == 0) burst = !burst;
      end
      rsp_stall <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  initial begin : req_side
    int               nfree;
    logic             k;
    logic [CNT_W-1:0] c;
    logic [BLK_W-1:0] b;
    blk_used    = '0;
    blk_used[0] = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_N; r++) begin
      offer_item(DIR_TAB[r].kind, DIR_TAB[r].cnt, DIR_TAB[r].blk, DIR_TAB[r].typed,
                 DIR_TAB[r].t_blk, DIR_TAB[r].t_st);
    end

    // mostly large allocations until the map is nearly full, then churn near full
    for (int n = 0; n < N_RAND; n++) begin
      nfree = NBLK - 1 - $countones(blk_used[NBLK-1:1]);
      k = KIND_ALLOC;
      c = CNT_W'($urandom_range(0, 31));
      b = BLK_W'($urandom_range(0, NBLK - 1));
      if (nfree > 48) begin
        if ($urandom_range(0, 9) < 9) begin
          c = CNT_W'($urandom_range(16, 31));
        end else begin
          k = KIND_FREE;
        end
      end else begin
        case ($urandom_range(0, 5))
          0, 1: begin
            k = KIND_FREE;
            for (int t = 0; t < 8 && !blk_used[b]; t++) b = BLK_W'($urandom_range(1, NBLK - 1));
          end
          2: k = KIND_FREE;
          3: begin
            if (nfree >= 1 && nfree <= MAX_REQ) c = CNT_W'(nfree);
            else c = CNT_W'($urandom_range(1, 31));
          end
          4: ;
          default: c = CNT_W'($urandom_range(1, 4));
        endcase
      end
      offer_item(k, c, b, 1'b0, '0, ST_GRANTED);
    end
    req_valid <= 1'b0;

    while (grant_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/ffba_pkg.sv
hdl/ffba_dp.sv
hdl/ffba_ctrl.sv
hdl/first_fit_block_allocator.sv
hdl/ffba_chk.sv
tb/first_fit_block_allocator_tb.sv
